// File: hdl/sips_pkg.sv
// ----------------------------------------------------------------------------
// sips_pkg
// Shared types and constants for the sorted insert-position search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sips_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);

  // Field widths
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned DATA_W  = 32;

  // Item function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic wr;    // write the table entry of the accepted item
    logic load;  // start a search: set bounds, issue first probe
    logic step;  // consume one probe result
  } sips_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty; // search range is empty from the outset
    logic stop;  // current probe ends the search
  } sips_status_t;

endpackage

`default_nettype wire

// File: hdl/sips_ctrl.sv
// ----------------------------------------------------------------------------
// sips_ctrl
// Sequencer for item acceptance, probe stepping and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module sips_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  func_i,
  input  wire sips_pkg::sips_status_t status_i,
  output      sips_pkg::sips_cmd_t   cmd_o,
  output      logic                  busy_o,
  output      logic                  done_o
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PROBE = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;
  logic take;

  assign take = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (func_i == sips_pkg::FUNC_SEARCH) begin
            cmd_o.load = 1'b1;
            if (status_i.empty) begin
              done_d = 1'b1;
            end else begin
              state_d = ST_PROBE;
            end
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        cmd_o.step = 1'b1;
        if (status_i.stop) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: hdl/sips_dpath.sv
// ----------------------------------------------------------------------------
// sips_dpath
// Entry table, count register, search bounds, probe compare and result.
// ----------------------------------------------------------------------------
`default_nettype none

module sips_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sips_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  wire logic [sips_pkg::INDEX_W-1:0]      entry_index_i,
  input  wire logic signed [sips_pkg::DATA_W-1:0] entry_value_i,
  input  wire logic signed [sips_pkg::DATA_W-1:0] search_target_i,
  input  wire sips_pkg::sips_cmd_t               cmd_i,
  output      sips_pkg::sips_status_t            status_o,
  output      logic [sips_pkg::CNT_W-1:0]        position_o,
  output      logic                              found_o
);

  localparam int unsigned CW = sips_pkg::CNT_W;
  localparam int unsigned AW = sips_pkg::ADDR_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(sips_pkg::TABLE_DEPTH);

  logic signed [sips_pkg::DATA_W-1:0] mem_q [sips_pkg::TABLE_DEPTH];
  logic signed [sips_pkg::DATA_W-1:0] rdata_q;
  logic signed [sips_pkg::DATA_W-1:0] target_q;

  logic [CW-1:0] count_q;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0] n_eff, mid_init;
  logic [CW-1:0] lo_lt, mid_lt, mid_ge;
  logic [CW-1:0] position_q;
  logic          found_q;
  logic          eq, lt, wr_ok;
  logic [AW-1:0] rd_addr;

  // Midpoint of [lo, hi), rounded down; only meaningful for lo < hi
  function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo,
                                           input logic [CW-1:0] hi);
    logic [CW-1:0] span;
    span   = hi - lo - CW'(1);
    mid_of = lo + (span >> 1);
  endfunction

  assign n_eff    = (count_q > DEPTH_C) ? DEPTH_C : count_q;
  assign mid_init = mid_of('0, n_eff);

  assign eq = (rdata_q == target_q);
  assign lt = (rdata_q < target_q);

  // Both successor probes worked out alongside the compare
  assign lo_lt  = mid_q + CW'(1);
  assign mid_lt = mid_of(lo_lt, hi_q);
  assign mid_ge = mid_of(lo_q, mid_q);

  always_comb begin
    lo_d  = lo_q;
    hi_d  = hi_q;
    mid_d = mid_q;
    if (cmd_i.load) begin
      lo_d  = '0;
      hi_d  = n_eff;
      mid_d = mid_init;
    end else if (cmd_i.step) begin
      if (lt) begin
        lo_d  = lo_lt;
        mid_d = mid_lt;
      end else begin
        hi_d  = mid_q;
        mid_d = mid_ge;
      end
    end
  end

  assign status_o.empty = (n_eff == '0);
  assign status_o.stop  = eq || !(lo_d < hi_d);

  assign rd_addr = mid_d[AW-1:0];
  assign wr_ok   = ({{(CW-sips_pkg::INDEX_W){1'b0}}, entry_index_i} < DEPTH_C);

  // Table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem_q[AW'(entry_index_i)] <= entry_value_i;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    if (cmd_i.load) begin
      target_q   <= search_target_i;
      position_q <= '0;
      found_q    <= 1'b0;
    end else if (cmd_i.step && status_o.stop) begin
      position_q <= eq ? mid_q : lo_d;
      found_q    <= eq;
    end
  end

  assign position_o = position_q;
  assign found_o    = found_q;

endmodule

`default_nettype wire

// File: hdl/sorted_insert_position_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_insert_position_search_unit
// Binary search for a target, or its insertion point, in a written table.
// ----------------------------------------------------------------------------
// Results are not back-pressured: done_o pulses high for one cycle with
// position_o/found_o valid, and the receiver must take the transfer then.
// An item is accepted on a rising edge with start_i high and busy_o low.
// A write item (func_i = 0) gives no result and leaves busy_o low. A search
// item runs one probe per cycle, each probe a single read of the table
// RAM, and holds busy_o while it makes at most k = ceil(log2(n+1)) probes
// (11 for a full 1024-entry table), n being the saturated entry count;
// the probe loop runs through the RAM's registered read port. done_o rises
// the cycle after the last probe, and a new item may be accepted in that
// same cycle. With an empty table done_o follows the accept directly.
// cfg_we_i/cfg_wdata_i load the entry count; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_position_search_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // config
  input  wire logic                               cfg_we_i,
  input  wire logic [sips_pkg::CNT_W-1:0]         cfg_wdata_i,
  // item input
  input  wire logic                               start_i,
  output      logic                               busy_o,
  input  wire logic                               func_i,
  input  wire logic [sips_pkg::INDEX_W-1:0]       entry_index_i,
  input  wire logic signed [sips_pkg::DATA_W-1:0] entry_value_i,
  input  wire logic signed [sips_pkg::DATA_W-1:0] search_target_i,
  // result
  output      logic                               done_o,
  output      logic [sips_pkg::CNT_W-1:0]         position_o,
  output      logic                               found_o
);

  sips_pkg::sips_cmd_t    cmd;
  sips_pkg::sips_status_t status;

  // Sequencer: idle / probing, plus the one-cycle result strobe
  sips_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // Table RAM, bounds registers, compare and result registers
  sips_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .entry_index_i   (entry_index_i),
    .entry_value_i   (entry_value_i),
    .search_target_i (search_target_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .position_o      (position_o),
    .found_o         (found_o)
  );

endmodule

`default_nettype wire
